>>> hdl/mmsm_pkg.sv
`timescale 1ns / 1ps

package mmsm_pkg;

  localparam int PIX_W        = 8;
  localparam int WIDTH_REG_W  = 9;
  localparam int HEIGHT_REG_W = 11;
  localparam int WIN_CELLS    = 9;
  localparam int WIN_CENTRE   = 4;
  localparam int SUM_W        = 12;   // nine cells of 255 at most
  localparam int CNT_W        = 4;    // zero to nine non-empty cells
  localparam int RECIP_W      = 16;
  localparam int RECIP_SHIFT  = 15;

  // beat function codes
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // register select codes (address bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // control that travels with one window into the mean stage
  typedef struct packed {
    logic pass;
    pix_t centre;
  } mean_ctl_t;

  // ceil(2^15 / d): exact floor division for every sum below 2304
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10923;
      4'd4:    r = 16'd8192;
      4'd5:    r = 16'd6554;
      4'd6:    r = 16'd5462;
      4'd7:    r = 16'd4682;
      4'd8:    r = 16'd4096;
      4'd9:    r = 16'd3641;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/mmsm_line_ram.sv
`timescale 1ns / 1ps

module mmsm_line_ram #(
  parameter int DEPTH  = 256,
  parameter int AW     = 8,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/mmsm_mean.sv
`timescale 1ns / 1ps

module mmsm_mean (
  input  logic                 clk,
  input  logic                 load,
  input  mmsm_pkg::pix_t       cells [mmsm_pkg::WIN_CELLS],
  input  mmsm_pkg::mean_ctl_t  ctl,
  output mmsm_pkg::pix_t       result
);

  localparam int PROD_W = mmsm_pkg::SUM_W + mmsm_pkg::RECIP_W;

  logic [mmsm_pkg::SUM_W-1:0] sum_c;
  logic [mmsm_pkg::SUM_W-1:0] sum_r;
  logic [mmsm_pkg::CNT_W-1:0] cnt_c;
  logic [mmsm_pkg::CNT_W-1:0] cnt_r;
  mmsm_pkg::mean_ctl_t        ctl_r;
  logic [PROD_W-1:0]          prod;

  // empty cells add zero, so only the count needs the mask
  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int i = 0; i < mmsm_pkg::WIN_CELLS; i++) begin
      sum_c = sum_c + mmsm_pkg::SUM_W'(cells[i]);
      cnt_c = cnt_c + mmsm_pkg::CNT_W'(cells[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= sum_c;
      cnt_r <= cnt_c;
      ctl_r <= ctl;
    end
  end

  assign prod = PROD_W'(sum_r) * PROD_W'(mmsm_pkg::recip(cnt_r));

  assign result = ctl_r.pass ? ctl_r.centre
                             : prod[mmsm_pkg::RECIP_SHIFT +: mmsm_pkg::PIX_W];

endmodule

>>> hdl/masked_mean_smoothing_3x3_core.sv
`timescale 1ns / 1ps
// A pixel beat that yields a result goes from S_CELL, which loads the mean stage, to S_MEAN,
// which loads the output register; a flush beat loads it from S_FLUSH; out_stall on a held
// result holds either state. in_stall is high outside S_IDLE, which a dropped beat never leaves;
// the line memory read-modify-write and the registered mean stage set the other states.
// Reset (rst_n low, synchronous): sequencer, counters and output valid clear, registers
// return to 12 columns by 18 rows; the line memory is not cleared and needs no pass.
module masked_mean_smoothing_3x3_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  mmsm_pkg::pix_t       in_pixel_in,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output mmsm_pkg::pix_t       out_pixel_out,
  output logic                 out_frame_end,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  // compare widths that hold both the register and the bound
  localparam int WX = (CW + 1 > mmsm_pkg::WIDTH_REG_W) ? CW + 1 : mmsm_pkg::WIDTH_REG_W;
  localparam int HX = (RW + 1 > mmsm_pkg::HEIGHT_REG_W) ? RW + 1 : mmsm_pkg::HEIGHT_REG_W;
  localparam int PW = mmsm_pkg::PIX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CELL,
    S_MEAN,
    S_FLUSH
  } state_t;

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  state_t                           state_r, state_nxt;
  logic [mmsm_pkg::WIDTH_REG_W-1:0]  width_r, width_nxt;
  logic [mmsm_pkg::HEIGHT_REG_W-1:0] height_r, height_nxt;
  logic [CW-1:0]                    a_col_r, a_col_nxt;   // next cell to arrive
  logic [RW-1:0]                    a_row_r, a_row_nxt;
  logic                             acc_full_r, acc_full_nxt;
  logic [CW-1:0]                    e_col_r, e_col_nxt;   // next cell to leave
  logic [RW-1:0]                    e_row_r, e_row_nxt;
  logic                             out_valid_r, out_valid_nxt;
  mmsm_pkg::pix_t                   out_pix_r, out_pix_nxt;
  logic                             out_fe_r, out_fe_nxt;
  mmsm_pkg::pix_t                   px_r;
  mmsm_pkg::pix_t                   win_r   [mmsm_pkg::WIN_CELLS];
  mmsm_pkg::pix_t                   win_nxt [mmsm_pkg::WIN_CELLS];

  // ---------------------------------------------------------------
  // Combinational nets
  // ---------------------------------------------------------------
  logic             in_accept;
  logic             cfg_wr;
  logic [WX-1:0]    width_x;
  logic [HX-1:0]    height_x;
  logic [CW-1:0]    w_m1;
  logic [RW-1:0]    h_m1;
  logic             acc_emit;
  logic             a_last;
  logic             e_last;
  logic             e_row_last;
  logic             e_border;
  logic             out_free;
  logic             out_load;
  logic             mean_load;
  mmsm_pkg::mean_ctl_t mean_ctl;
  mmsm_pkg::pix_t   mean_result;
  logic             ram_rd_en;
  logic [CW-1:0]    ram_rd_addr;
  logic [2*PW-1:0]  ram_rd_data;
  logic             ram_wr_en;
  logic [2*PW-1:0]  ram_wr_data;
  mmsm_pkg::pix_t   ram_up;
  mmsm_pkg::pix_t   ram_mid;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // effective frame size, as last column and last row: zero counts as one, clamp to bound
  assign width_x  = WX'(width_r);
  assign height_x = HX'(height_r);

  always_comb begin
    if (width_x == '0) begin
      w_m1 = '0;
    end else if (width_x > WX'(MAX_WIDTH)) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(width_x - WX'(1));
    end
    if (height_x == '0) begin
      h_m1 = '0;
    end else if (height_x > HX'(MAX_HEIGHT)) begin
      h_m1 = RW'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = RW'(height_x - HX'(1));
    end
  end

  // the cell now arriving is at least one row and one cell past the frame start
  assign acc_emit   = (a_row_r > RW'(1)) || ((a_row_r == RW'(1)) && (a_col_r != '0));
  assign a_last     = (a_row_r == h_m1) && (a_col_r == w_m1);
  assign e_row_last = (e_row_r == h_m1);
  assign e_last     = e_row_last && (e_col_r == w_m1);
  assign e_border   = (e_row_r == '0) || e_row_last || (e_col_r == '0) || (e_col_r == w_m1);

  assign out_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------
  // Line memory: one word per column holds {upper row, middle row}
  // ---------------------------------------------------------------
  assign ram_rd_en   = in_accept;
  assign ram_rd_addr = (in_func == mmsm_pkg::FUNC_FLUSH) ? e_col_r : a_col_r;
  assign ram_wr_en   = (state_r == S_CELL);
  // shift the column down: middle moves to upper, the new cell becomes middle
  assign ram_wr_data = {ram_mid, px_r};
  assign {ram_up, ram_mid} = ram_rd_data;

  mmsm_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .AW     (CW),
    .DATA_W (2 * PW)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (a_col_r),
    .wr_data (ram_wr_data)
  );

  // ---------------------------------------------------------------
  // Window: advance one column, new column enters on the right
  // ---------------------------------------------------------------
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]     = win_r[r*3 + 1];
      win_nxt[r*3 + 1] = win_r[r*3 + 2];
    end
    win_nxt[2] = ram_up;
    win_nxt[5] = ram_mid;
    win_nxt[8] = px_r;
  end

  // empty centre and border cells pass through unchanged
  assign mean_ctl.centre = win_nxt[mmsm_pkg::WIN_CENTRE];
  assign mean_ctl.pass   = (win_nxt[mmsm_pkg::WIN_CENTRE] == '0) || e_border;

  mmsm_mean u_mean (
    .clk    (clk),
    .load   (mean_load),
    .cells  (win_nxt),
    .ctl    (mean_ctl),
    .result (mean_result)
  );

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    a_col_nxt    = a_col_r;
    a_row_nxt    = a_row_r;
    acc_full_nxt = acc_full_r;
    e_col_nxt    = e_col_r;
    e_row_nxt    = e_row_r;
    out_pix_nxt  = out_pix_r;
    out_fe_nxt   = out_fe_r;
    out_load     = 1'b0;
    mean_load    = 1'b0;

    case (state_r)
      S_IDLE: begin
        // pixels after a full frame and flushes before it are dropped
        if (in_accept) begin
          if (in_func == mmsm_pkg::FUNC_PIXEL && !acc_full_r) begin
            state_nxt = S_CELL;
          end else if (in_func == mmsm_pkg::FUNC_FLUSH && acc_full_r) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_CELL: begin
        // advance the arrival position; the memory write-back happens this cycle
        if (a_col_r == w_m1) begin
          a_col_nxt = '0;
          a_row_nxt = RW'(a_row_r + RW'(1));
        end else begin
          a_col_nxt = CW'(a_col_r + CW'(1));
        end
        if (a_last) begin
          acc_full_nxt = 1'b1;
        end
        if (acc_emit) begin
          mean_load = 1'b1;
          if (e_col_r == w_m1) begin
            e_col_nxt = '0;
            e_row_nxt = RW'(e_row_r + RW'(1));
          end else begin
            e_col_nxt = CW'(e_col_r + CW'(1));
          end
          state_nxt = S_MEAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_MEAN: begin
        // hold until the output register frees up
        if (out_free) begin
          out_load    = 1'b1;
          out_pix_nxt = mean_result;
          out_fe_nxt  = 1'b0;
          state_nxt   = S_IDLE;
        end
      end

      S_FLUSH: begin
        // the last row still sits in the middle line, the row above it in the upper line
        if (out_free) begin
          out_load    = 1'b1;
          out_pix_nxt = e_row_last ? ram_mid : ram_up;
          out_fe_nxt  = e_last;
          if (e_last) begin
            // frame done: start over
            a_col_nxt    = '0;
            a_row_nxt    = '0;
            acc_full_nxt = 1'b0;
            e_col_nxt    = '0;
            e_row_nxt    = '0;
          end else if (e_col_r == w_m1) begin
            e_col_nxt = '0;
            e_row_nxt = RW'(e_row_r + RW'(1));
          end else begin
            e_col_nxt = CW'(e_col_r + CW'(1));
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a register write abandons the frame in progress
    if (cfg_wr) begin
      case (paddr[2])
        mmsm_pkg::REG_WIDTH:  width_nxt  = pwdata[mmsm_pkg::WIDTH_REG_W-1:0];
        mmsm_pkg::REG_HEIGHT: height_nxt = pwdata[mmsm_pkg::HEIGHT_REG_W-1:0];
        default: begin
        end
      endcase
      a_col_nxt    = '0;
      a_row_nxt    = '0;
      acc_full_nxt = 1'b0;
      e_col_nxt    = '0;
      e_row_nxt    = '0;
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= mmsm_pkg::WIDTH_REG_W'(12);
      height_r    <= mmsm_pkg::HEIGHT_REG_W'(18);
      a_col_r     <= '0;
      a_row_r     <= '0;
      acc_full_r  <= 1'b0;
      e_col_r     <= '0;
      e_row_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      a_col_r     <= a_col_nxt;
      a_row_r     <= a_row_nxt;
      acc_full_r  <= acc_full_nxt;
      e_col_r     <= e_col_nxt;
      e_row_r     <= e_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    out_pix_r <= out_pix_nxt;
    out_fe_r  <= out_fe_nxt;
    if (in_accept) begin
      px_r <= in_pixel_in;
    end
    if (state_r == S_CELL) begin
      win_r <= win_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Register read-back and outputs
  // ---------------------------------------------------------------
  always_comb begin
    case (paddr[2])
      mmsm_pkg::REG_WIDTH:  prdata = 32'(width_r);
      mmsm_pkg::REG_HEIGHT: prdata = 32'(height_r);
      default:              prdata = '0;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_frame_end = out_fe_r;

endmodule

>>> test/tb_masked_mean_smoothing_3x3_core.sv
`timescale 1ns / 1ps

module tb_masked_mean_smoothing_3x3_core;

  localparam int GRID_MAX_W  = 256;
  localparam int GRID_MAX_H  = 1024;
  localparam int CELL_TARGET = 1700;     // live beats to feed before stopping
  localparam int CYCLE_LIMIT = 400000;   // generous ceiling on the whole run
  localparam int SETTLE      = 8;        // covers the registered pipe plus margin

  typedef struct packed {
    logic           func;
    mmsm_pkg::pix_t pix;
  } beat_t;

  typedef struct packed {
    mmsm_pkg::pix_t pix;
    logic           last;
  } smoothed_t;

  logic           clk           = 1'b0;
  logic           rst_n         = 1'b0;
  logic           in_valid      = 1'b0;
  logic           in_stall;
  logic           in_func       = mmsm_pkg::FUNC_PIXEL;
  mmsm_pkg::pix_t in_pixel_in   = '0;
  logic           out_valid;
  logic           out_stall     = 1'b0;
  mmsm_pkg::pix_t out_pixel_out;
  logic           out_frame_end;
  logic           psel          = 1'b0;
  logic           penable       = 1'b0;
  logic           pwrite        = 1'b0;
  logic [2:0]     paddr         = '0;
  logic [31:0]    pwdata        = '0;
  logic [31:0]    prdata;
  logic           pready;

  masked_mean_smoothing_3x3_core #(
    .MAX_WIDTH (GRID_MAX_W),
    .MAX_HEIGHT(GRID_MAX_H)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel_out(out_pixel_out),
    .out_frame_end(out_frame_end),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Beats waiting to be driven, and smoothed cells the block still owes us.
  beat_t       feed_q[$];
  smoothed_t   smoothed_q[$];
  int          fed  = 0;
  int          errs = 0;
  int unsigned tick = 0;

  // Own copy of the grid state: raw register values, line stores, window, counts.
  int unsigned    grid_w_reg;
  int unsigned    grid_h_reg;
  mmsm_pkg::pix_t upper_row[GRID_MAX_W];
  mmsm_pkg::pix_t middle_row[GRID_MAX_W];
  mmsm_pkg::pix_t win[9];
  int unsigned    n_accepted;
  int unsigned    n_emitted;

  // Zero and oversize register values map onto the legal range.
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void grid_restart();
    n_accepted = 0;
    n_emitted  = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
  endfunction

  // Advance the grid by one accepted beat and queue the cell it releases, if any.
  function automatic void advance_grid(input logic func, input mmsm_pkg::pix_t px);
    int unsigned    w, h, total, er, ec, col, sum, cnt;
    mmsm_pkg::pix_t up, mid, res;
    smoothed_t      s;
    w     = clamp_dim(grid_w_reg, GRID_MAX_W);
    h     = clamp_dim(grid_h_reg, GRID_MAX_H);
    total = w * h;
    er    = n_emitted / w;
    ec    = n_emitted % w;
    if (func == mmsm_pkg::FUNC_PIXEL) begin
      // drop cells that arrive once the frame is complete
      if (n_accepted >= total) return;
      col             = n_accepted % w;
      up              = upper_row[col];
      mid             = middle_row[col];
      upper_row[col]  = mid;
      middle_row[col] = px;
      for (int r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = px;
      n_accepted++;
      // nothing leaves until the window centre holds a real cell
      if (n_accepted < w + 2) return;
      res = win[4];
      if (res != 0 && er != 0 && er + 1 < h && ec != 0 && ec + 1 < w) begin
        sum = 0;
        cnt = 0;
        for (int i = 0; i < 9; i++) begin
          if (win[i] != 0) begin
            sum += win[i];
            cnt++;
          end
        end
        res = mmsm_pkg::pix_t'(sum / cnt);
      end
      s.pix  = res;
      s.last = 1'b0;
      smoothed_q.insert(smoothed_q.size(), s);
      n_emitted++;
    end else begin
      // drop flushes until the frame is complete
      if (n_accepted < total || n_emitted >= total) return;
      // the tail cells sit in the line stores; all are on the border
      s.pix  = (er + 1 == h) ? middle_row[ec] : upper_row[ec];
      s.last = (n_emitted + 1 == total);
      smoothed_q.insert(smoothed_q.size(), s);
      n_emitted++;
      if (n_emitted == total) grid_restart();
    end
  endfunction

  // Input driver: bursts of random length, idle gaps between them.
  beat_t next_beat;
  int    burst_left = 0;
  int    idle_left  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      // the beat on the bus (if any) went through; pick what to show next
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        next_beat   = feed_q.pop_front();
        in_valid    <= 1'b1;
        in_func     <= next_beat.func;
        in_pixel_in <= next_beat.pix;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // now and then run a long burst with no gap at all
          burst_left = $urandom_range(0, 23);
          idle_left  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure: switch among free, light, heavy and periodic stalls.
  int stall_span = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(50, 300);
      stall_mode = $urandom_range(0, 3);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ((tick % 5) < 2);
    endcase
  end

  // Monitor: predict on every accepted input beat, then check any result beat.
  smoothed_t got_exp;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) advance_grid(in_func, in_pixel_in);
      if (out_valid && !out_stall) begin
        if (smoothed_q.size() == 0) begin
          if (errs < 10)
            $display("unexpected result beat: pixel %0d frame_end %0b",
                     out_pixel_out, out_frame_end);
          errs++;
        end else begin
          got_exp = smoothed_q.pop_front();
          if (out_pixel_out !== got_exp.pix || out_frame_end !== got_exp.last) begin
            if (errs < 10)
              $display("mismatch: expected pixel %0d frame_end %0b, got pixel %0d frame_end %0b",
                       got_exp.pix, got_exp.last, out_pixel_out, out_frame_end);
            errs++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    tick <= tick + 1;
    if (tick >= CYCLE_LIMIT) begin
      $display("tb_masked_mean_smoothing_3x3_core: done, errors");
      $finish;
    end
  end

  // Queue one beat; live beats count toward the stimulus total, dropped ones do not.
  task automatic push_beat(input logic func, input mmsm_pkg::pix_t px, input logic live);
    beat_t b;
    b.func = func;
    b.pix  = px;
    feed_q.insert(feed_q.size(), b);
    if (live) fed++;
  endtask

  // Mostly cells of random value, with plenty of empties and extremes.
  function automatic mmsm_pkg::pix_t pick_cell();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'd0;
    if (r < 40) return 8'd255;
    if (r < 45) return 8'd1;
    return mmsm_pkg::pix_t'($urandom_range(1, 254));
  endfunction

  // Any value for the ignored pixel field of a flush beat.
  function automatic mmsm_pkg::pix_t pick_junk();
    return mmsm_pkg::pix_t'($urandom_range(0, 255));
  endfunction

  // Hold until every beat is in and every owed cell is out, then let the pipe settle.
  task automatic wait_drained();
    @(negedge clk);
    while (feed_q.size() != 0 || in_valid || smoothed_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Setup then access phase; the register takes the value at the access edge.
  task automatic write_reg(input logic sel, input int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == mmsm_pkg::REG_WIDTH) grid_w_reg = value & 32'h1FF;
    else                            grid_h_reg = value & 32'h7FF;
    // any write throws away the frame in progress
    grid_restart();
  endtask

  // Configure, then feed one frame; a non-negative cut abandons it after that many cells.
  task automatic run_frame(input int unsigned wv, input int unsigned hv, input int cut);
    int unsigned w, h, total, n, pick;
    pick = $urandom_range(0, 2);
    // always write at least one register so an abandoned frame is cleared
    if (wv != grid_w_reg || pick != 1) write_reg(mmsm_pkg::REG_WIDTH, wv);
    if (hv != grid_h_reg || pick != 0) write_reg(mmsm_pkg::REG_HEIGHT, hv);
    w     = clamp_dim(grid_w_reg, GRID_MAX_W);
    h     = clamp_dim(grid_h_reg, GRID_MAX_H);
    total = w * h;
    n     = (cut < 0) ? total : cut;
    for (int k = 0; k < n; k++) begin
      // early flush: the frame is not complete, so the block drops it
      if ($urandom_range(0, 39) == 0) push_beat(mmsm_pkg::FUNC_FLUSH, pick_junk(), 1'b0);
      push_beat(mmsm_pkg::FUNC_PIXEL, pick_cell(), 1'b1);
      // pause the sender mid-frame until every owed cell has come back
      if ((k == n / 2 && n > 100) || $urandom_range(0, 149) == 0) wait_drained();
    end
    if (cut < 0) begin
      // stray cells after the last one of the frame are dropped
      repeat ($urandom_range(0, 1)) push_beat(mmsm_pkg::FUNC_PIXEL, pick_cell(), 1'b0);
      repeat ((total < w + 1) ? total : w + 1)
        push_beat(mmsm_pkg::FUNC_FLUSH, pick_junk(), 1'b1);
      // a flush after the frame end finds an empty frame and is dropped
      if ($urandom_range(0, 3) == 0) push_beat(mmsm_pkg::FUNC_FLUSH, pick_junk(), 1'b0);
    end
    wait_drained();
  endtask

  initial begin
    int          iter;
    int          cut;
    int unsigned wv, hv;

    grid_w_reg = 12;
    grid_h_reg = 18;
    for (int i = 0; i < GRID_MAX_W; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    grid_restart();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: 3x3 frame with one interior cell, mixed empties and extremes.
    write_reg(mmsm_pkg::REG_WIDTH, 3);
    write_reg(mmsm_pkg::REG_HEIGHT, 3);
    push_beat(mmsm_pkg::FUNC_FLUSH, 8'd0, 1'b0);    // flush before the frame is complete
    push_beat(mmsm_pkg::FUNC_PIXEL, 8'd1, 1'b1);
    push_beat(mmsm_pkg::FUNC_PIXEL, 8'd0, 1'b1);
    push_beat(mmsm_pkg::FUNC_PIXEL, 8'd255, 1'b1);
    push_beat(mmsm_pkg::FUNC_PIXEL, 8'd255, 1'b1);
    push_beat(mmsm_pkg::FUNC_PIXEL, 8'd200, 1'b1);
    push_beat(mmsm_pkg::FUNC_PIXEL, 8'd0, 1'b1);
    push_beat(mmsm_pkg::FUNC_PIXEL, 8'd128, 1'b1);
    push_beat(mmsm_pkg::FUNC_PIXEL, 8'd255, 1'b1);
    push_beat(mmsm_pkg::FUNC_PIXEL, 8'd7, 1'b1);
    push_beat(mmsm_pkg::FUNC_PIXEL, 8'd99, 1'b0);   // cell while the frame is complete
    repeat (4) push_beat(mmsm_pkg::FUNC_FLUSH, 8'd255, 1'b1);
    push_beat(mmsm_pkg::FUNC_FLUSH, 8'd0, 1'b0);    // flush after the frame end
    wait_drained();

    // Directed: zero registers clamp to a single-cell frame, drained by one flush.
    write_reg(mmsm_pkg::REG_WIDTH, 0);
    write_reg(mmsm_pkg::REG_HEIGHT, 0);
    push_beat(mmsm_pkg::FUNC_PIXEL, 8'd255, 1'b1);
    push_beat(mmsm_pkg::FUNC_FLUSH, 8'd0, 1'b1);
    wait_drained();

    // Random frames, with the register extremes placed at fixed points.
    iter = 0;
    while (fed < CELL_TARGET) begin
      cut = -1;
      case (iter)
        0: begin
          wv = 12;
          hv = 18;
        end
        2: begin
          // widest row saturates to the line store depth, all cells flushed out
          wv = 511;
          hv = 1;
        end
        5: begin
          wv  = 0;
          hv  = 2047;
          cut = 40;
        end
        8: begin
          // tallest frame: interior column runs down many rows, then abandon
          wv  = 3;
          hv  = 2047;
          cut = 60;
        end
        default: begin
          if ($urandom_range(0, 9) < 8) begin
            wv = $urandom_range(0, 12);
            hv = $urandom_range(0, 8);
          end else begin
            wv = $urandom_range(13, 40);
            hv = $urandom_range(1, 4);
          end
          if ($urandom_range(0, 7) == 0)
            cut = $urandom_range(0, clamp_dim(wv, GRID_MAX_W) * clamp_dim(hv, GRID_MAX_H) - 1);
        end
      endcase
      run_frame(wv, hv, cut);
      iter++;
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (smoothed_q.size() != 0) errs++;
    if (errs == 0) begin
      $display("tb_masked_mean_smoothing_3x3_core: done, clean");
    end else begin
      $display("tb_masked_mean_smoothing_3x3_core: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/mmsm_pkg.sv
hdl/mmsm_line_ram.sv
hdl/mmsm_mean.sv
hdl/masked_mean_smoothing_3x3_core.sv
test/tb_masked_mean_smoothing_3x3_core.sv
